// ===== design/obcq_pkg.sv =====
// ----------------------------------------------------------------------------
// obcq_pkg
// Shared widths, codes and types for the oriented box collision query.
// ----------------------------------------------------------------------------
package obcq_pkg;

  localparam int FRAC  = 16;
  localparam int CW    = 32;
  localparam int HW    = 31;
  localparam int MW    = 17;
  localparam int AW    = 18;
  localparam int NW    = 18;
  localparam int DW    = CW + 1;
  localparam int PW    = DW + AW;
  localparam int LW    = PW + 1 - FRAC;
  localparam int BW    = LW + 2;
  localparam int RW    = 31;
  localparam int SW    = $clog2(BW - RW + 1);
  localparam int ROOTW = RW + 1;
  localparam int RADW  = 2 * ROOTW;
  localparam int QW    = FRAC + 1;

  localparam int FRONT_STAGES = 8;
  localparam int SQ_STAGES    = ROOTW / 2;
  localparam int DIV_STAGES   = (QW + 1) / 2;
  localparam int BACK_STAGES  = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQ_STAGES + DIV_STAGES + BACK_STAGES;

  localparam logic signed [NW-1:0] N_POS    = NW'(longint'(1) << FRAC);
  localparam logic signed [NW-1:0] N_NEG    = -N_POS;
  localparam logic signed [CW-1:0] DIST_MAX = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0] DIST_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    REG_INSIDE,
    REG_SHELL,
    REG_SIDE,
    REG_CORNER
  } region_t;

  typedef enum logic [2:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_HALF_WIDTH,
    CFG_HALF_HEIGHT,
    CFG_AXIS_X,
    CFG_AXIS_Y,
    CFG_MARGIN
  } cfg_index_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [HW-1:0]        half_width;
    logic [HW-1:0]        half_height;
    logic signed [AW-1:0] axis_x;
    logic signed [AW-1:0] axis_y;
    logic [MW-1:0]        margin;
  } cfg_t;

  typedef struct packed {
    logic                 corner;
    region_t              region;
    logic signed [CW-1:0] sdist;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 neg_x;
    logic                 neg_y;
    logic [SW-1:0]        sh;
  } item_t;

endpackage

// ===== design/oriented_box_collision_query.sv =====
// ----------------------------------------------------------------------------
// oriented_box_collision_query
// Signed distance, world normal and region of a point against an oriented box.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the depth is set by the 32-bit square root
// and the 17-bit corner divide, each resolving two bits per stage.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
module oriented_box_collision_query (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [obcq_pkg::CW-1:0] query_x,
  input  logic signed [obcq_pkg::CW-1:0] query_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [obcq_pkg::CW-1:0] distance,
  output logic signed [obcq_pkg::NW-1:0] normal_x,
  output logic signed [obcq_pkg::NW-1:0] normal_y,
  output logic [1:0]                    region
);
  import obcq_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.half_width  <= HW'(65536);
      cfg.half_height <= HW'(65536);
      cfg.axis_x      <= AW'(65536);
      cfg.axis_y      <= '0;
      cfg.margin      <= MW'(1311);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CENTER_X:    cfg.center_x    <= cfg_data;
        CFG_CENTER_Y:    cfg.center_y    <= cfg_data;
        CFG_HALF_WIDTH:  cfg.half_width  <= cfg_data[HW-1:0];
        CFG_HALF_HEIGHT: cfg.half_height <= cfg_data[HW-1:0];
        CFG_AXIS_X:      cfg.axis_x      <= cfg_data[AW-1:0];
        CFG_AXIS_Y:      cfg.axis_y      <= cfg_data[AW-1:0];
        CFG_MARGIN:      cfg.margin      <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  logic             f_in_ready, f_valid, f_ready;
  item_t            f_item;
  logic [RW-1:0]    f_mx, f_my;
  logic [RADW-1:0]  f_rad;
  logic             s_valid, s_ready;
  item_t            s_item;
  logic [RW-1:0]    s_mx, s_my;
  logic [ROOTW-1:0] s_root;
  logic             d_valid, d_ready;
  item_t            d_item;
  logic [ROOTW-1:0] d_root;
  logic [QW-1:0]    d_qx, d_qy;

  assign in_stall = !f_in_ready;

  obcq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (f_in_ready),
    .query_x   (query_x),
    .query_y   (query_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item),
    .out_mx    (f_mx),
    .out_my    (f_my),
    .out_rad   (f_rad)
  );

  obcq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .in_mx     (f_mx),
    .in_my     (f_my),
    .in_rad    (f_rad),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_item  (s_item),
    .out_mx    (s_mx),
    .out_my    (s_my),
    .out_root  (s_root)
  );

  obcq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_item   (s_item),
    .in_mx     (s_mx),
    .in_my     (s_my),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_item  (d_item),
    .out_root  (d_root),
    .out_qx    (d_qx),
    .out_qy    (d_qy)
  );

  obcq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_item   (d_item),
    .in_root   (d_root),
    .in_qx     (d_qx),
    .in_qy     (d_qy),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .distance  (distance),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .region    (region)
  );

endmodule

// ===== design/obcq_front.sv =====
// ----------------------------------------------------------------------------
// obcq_front
// Box frame transform, region classification and corner radicand.
// ----------------------------------------------------------------------------
module obcq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  obcq_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [obcq_pkg::CW-1:0] query_x,
  input  logic signed [obcq_pkg::CW-1:0] query_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output obcq_pkg::item_t               out_item,
  output logic [obcq_pkg::RW-1:0]       out_mx,
  output logic [obcq_pkg::RW-1:0]       out_my,
  output logic [obcq_pkg::RADW-1:0]     out_rad
);
  import obcq_pkg::*;

  logic [FRONT_STAGES-1:0] v;
  logic [FRONT_STAGES:0]   rdy;

  logic signed [DW-1:0] dx1, dy1;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [LW-1:0] lx3, ly3;
  logic signed [BW-1:0] c4 [4];
  logic                 band4, xl4, xh4, yl4, yh4;
  item_t                item5, item6, item7, item8;
  logic [BW-1:0]        mx5, my5;
  logic [RW-1:0]        mx6, my6, mx7, my7, mx8, my8;
  logic [2*RW-1:0]      sx7, sy7;
  logic [RADW-1:0]      rad8;

  function automatic logic [BW-1:0] mag(input logic signed [BW-1:0] a);
    return a[BW-1] ? $unsigned(-a) : $unsigned(a);
  endfunction

  always_comb begin
    rdy[FRONT_STAGES] = out_ready;
    for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 4 terms
  logic signed [BW-1:0] wv, hv, wm, hm, we, he, lxe, lye;
  logic signed [BW-1:0] mv, ev;
  logic [PW:0]          sa, sb;

  always_comb begin
    sa  = {p1[PW-1], p1} + {p2[PW-1], p2};
    sb  = {p3[PW-1], p3} - {p4[PW-1], p4};
    wv  = $signed({{(BW-HW){1'b0}}, cfg.half_width});
    hv  = $signed({{(BW-HW){1'b0}}, cfg.half_height});
    mv  = $signed({{(BW-MW){1'b0}}, cfg.margin});
    ev  = $signed({{(BW-MW+1){1'b0}}, cfg.margin[MW-1:1]});
    wm  = wv + mv;
    hm  = hv + mv;
    we  = wv + ev;
    he  = hv + ev;
    lxe = {{(BW-LW){lx3[LW-1]}}, lx3};
    lye = {{(BW-LW){ly3[LW-1]}}, ly3};
  end

  // stage 5 terms
  logic [BW-1:0]        m0, m1, m2, m3, mb01, mb23;
  logic [1:0]           b01, b23, sel;
  logic signed [BW-1:0] dwide;
  item_t                it5;
  logic [BW-1:0]        mx5c, my5c;

  always_comb begin
    m0   = mag(c4[0]);
    m1   = mag(c4[1]);
    m2   = mag(c4[2]);
    m3   = mag(c4[3]);
    b01  = (m1 < m0) ? 2'd1 : 2'd0;
    mb01 = (m1 < m0) ? m1 : m0;
    b23  = (m3 < m2) ? 2'd3 : 2'd2;
    mb23 = (m3 < m2) ? m3 : m2;
    sel  = (mb23 < mb01) ? b23 : b01;

    it5        = '0;
    it5.region = REG_INSIDE;
    dwide      = '0;
    mx5c       = '0;
    my5c       = '0;
    if (!band4) begin
      dwide = c4[sel];
      case (sel)
        2'd0:    it5.nx = N_POS;
        2'd1:    it5.nx = N_NEG;
        2'd2:    it5.ny = N_POS;
        default: it5.ny = N_NEG;
      endcase
    end else if ((xl4 || xh4) && (yl4 || yh4)) begin
      it5.corner = 1'b1;
      it5.region = REG_CORNER;
      it5.neg_x  = xl4;
      it5.neg_y  = yl4;
      mx5c       = xl4 ? m0 : m1;
      my5c       = yl4 ? m2 : m3;
    end else if (xl4) begin
      it5.region = REG_SIDE;
      dwide      = -c4[0];
      it5.nx     = N_NEG;
    end else if (xh4) begin
      it5.region = REG_SIDE;
      dwide      = -c4[1];
      it5.nx     = N_POS;
    end else if (yl4) begin
      it5.region = REG_SIDE;
      dwide      = -c4[2];
      it5.ny     = N_NEG;
    end else if (yh4) begin
      it5.region = REG_SIDE;
      dwide      = -c4[3];
      it5.ny     = N_POS;
    end else begin
      it5.region = REG_SHELL;
      dwide      = -c4[sel];
      case (sel)
        2'd0:    it5.nx = N_NEG;
        2'd1:    it5.nx = N_POS;
        2'd2:    it5.ny = N_NEG;
        default: it5.ny = N_POS;
      endcase
    end
    if (dwide > DIST_MAX) begin
      it5.sdist = DIST_MAX;
    end else if (dwide < DIST_MIN) begin
      it5.sdist = DIST_MIN;
    end else begin
      it5.sdist = dwide[CW-1:0];
    end
  end

  // stage 6: common shift to bring both offsets below 2^31
  logic [BW-1:0] ormag;
  logic [SW-1:0] sh6;
  item_t         it6;

  always_comb begin
    ormag = mx5 | my5;
    sh6   = '0;
    for (int i = RW; i < BW; i++) begin
      if (ormag[i]) begin
        sh6 = SW'(i - RW + 1);
      end
    end
    it6    = item5;
    it6.sh = sh6;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx1 <= {query_x[CW-1], query_x} - {cfg.center_x[CW-1], cfg.center_x};
      dy1 <= {query_y[CW-1], query_y} - {cfg.center_y[CW-1], cfg.center_y};
    end
    if (rdy[1]) begin
      p1 <= dx1 * $signed(cfg.axis_x);
      p2 <= dy1 * $signed(cfg.axis_y);
      p3 <= dy1 * $signed(cfg.axis_x);
      p4 <= dx1 * $signed(cfg.axis_y);
    end
    if (rdy[2]) begin
      lx3 <= sa[PW:FRAC];
      ly3 <= sb[PW:FRAC];
    end
    if (rdy[3]) begin
      band4 <= (lxe < -we) || (lye < -he) || (lxe > we) || (lye > he);
      xl4   <= lxe < -wm;
      xh4   <= lxe > wm;
      yl4   <= lye < -hm;
      yh4   <= lye > hm;
      if ((lxe < -we) || (lye < -he) || (lxe > we) || (lye > he)) begin
        c4[0] <= lxe + wm;
        c4[1] <= wm - lxe;
        c4[2] <= lye + hm;
        c4[3] <= hm - lye;
      end else begin
        c4[0] <= lxe + wv;
        c4[1] <= wv - lxe;
        c4[2] <= lye + hv;
        c4[3] <= hv - lye;
      end
    end
    if (rdy[4]) begin
      item5 <= it5;
      mx5   <= mx5c;
      my5   <= my5c;
    end
    if (rdy[5]) begin
      item6 <= it6;
      mx6   <= RW'(mx5 >> sh6);
      my6   <= RW'(my5 >> sh6);
    end
    if (rdy[6]) begin
      item7 <= item6;
      mx7   <= mx6;
      my7   <= my6;
      sx7   <= mx6 * mx6;
      sy7   <= my6 * my6;
    end
    if (rdy[7]) begin
      item8 <= item7;
      mx8   <= mx7;
      my8   <= my7;
      rad8  <= {{(RADW-2*RW){1'b0}}, sx7} + {{(RADW-2*RW){1'b0}}, sy7};
    end
  end

  assign out_item = item8;
  assign out_mx   = mx8;
  assign out_my   = my8;
  assign out_rad  = rad8;

endmodule

// ===== design/obcq_sqrt.sv =====
// ----------------------------------------------------------------------------
// obcq_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module obcq_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  obcq_pkg::item_t             in_item,
  input  logic [obcq_pkg::RW-1:0]     in_mx,
  input  logic [obcq_pkg::RW-1:0]     in_my,
  input  logic [obcq_pkg::RADW-1:0]   in_rad,
  output logic                        out_valid,
  input  logic                        out_ready,
  output obcq_pkg::item_t             out_item,
  output logic [obcq_pkg::RW-1:0]     out_mx,
  output logic [obcq_pkg::RW-1:0]     out_my,
  output logic [obcq_pkg::ROOTW-1:0]  out_root
);
  import obcq_pkg::*;

  typedef struct packed {
    logic [ROOTW+1:0] rem;
    logic [ROOTW-1:0] root;
    logic [RADW-1:0]  rad;
    logic [RW-1:0]    mx;
    logic [RW-1:0]    my;
    item_t            item;
  } sq_t;

  function automatic sq_t sq_step(input sq_t a);
    sq_t              b;
    logic [ROOTW+1:0] rs;
    logic [ROOTW+1:0] trial;
    b     = a;
    rs    = {a.rem[ROOTW-1:0], a.rad[RADW-1:RADW-2]};
    trial = {a.root, 2'b01};
    if (rs >= trial) begin
      b.rem  = rs - trial;
      b.root = {a.root[ROOTW-2:0], 1'b1};
    end else begin
      b.rem  = rs;
      b.root = {a.root[ROOTW-2:0], 1'b0};
    end
    b.rad = a.rad << 2;
    return b;
  endfunction

  logic [SQ_STAGES-1:0] v;
  logic [SQ_STAGES:0]   rdy;
  sq_t                  st  [SQ_STAGES];
  sq_t                  nxt [SQ_STAGES];

  always_comb begin
    rdy[SQ_STAGES] = out_ready;
    for (int k = SQ_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_comb begin
    sq_t cur;
    cur.rem  = '0;
    cur.root = '0;
    cur.rad  = in_rad;
    cur.mx   = in_mx;
    cur.my   = in_my;
    cur.item = in_item;
    cur      = sq_step(sq_step(cur));
    nxt[0]   = cur;
    for (int k = 1; k < SQ_STAGES; k++) begin
      nxt[k] = sq_step(sq_step(st[k-1]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < SQ_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (rdy[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[SQ_STAGES-1];
  assign out_item  = st[SQ_STAGES-1].item;
  assign out_mx    = st[SQ_STAGES-1].mx;
  assign out_my    = st[SQ_STAGES-1].my;
  assign out_root  = st[SQ_STAGES-1].root;

endmodule

// ===== design/obcq_div.sv =====
// ----------------------------------------------------------------------------
// obcq_div
// Twin pipelined restoring dividers for the corner normal, two bits a stage.
// ----------------------------------------------------------------------------
module obcq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  obcq_pkg::item_t             in_item,
  input  logic [obcq_pkg::RW-1:0]     in_mx,
  input  logic [obcq_pkg::RW-1:0]     in_my,
  input  logic [obcq_pkg::ROOTW-1:0]  in_root,
  output logic                        out_valid,
  input  logic                        out_ready,
  output obcq_pkg::item_t             out_item,
  output logic [obcq_pkg::ROOTW-1:0]  out_root,
  output logic [obcq_pkg::QW-1:0]     out_qx,
  output logic [obcq_pkg::QW-1:0]     out_qy
);
  import obcq_pkg::*;

  typedef struct packed {
    logic [ROOTW:0]   remx;
    logic [ROOTW:0]   remy;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
    logic [QW-1:0]    tx;
    logic [QW-1:0]    ty;
    logic [ROOTW-1:0] r;
    item_t            item;
  } dv_t;

  function automatic dv_t dv_step(input dv_t a);
    dv_t          b;
    logic [ROOTW:0] rsx;
    logic [ROOTW:0] rsy;
    logic [ROOTW:0] rw;
    b   = a;
    rw  = {1'b0, a.r};
    rsx = {a.remx[ROOTW-1:0], a.tx[QW-1]};
    rsy = {a.remy[ROOTW-1:0], a.ty[QW-1]};
    if (rsx >= rw) begin
      b.remx = rsx - rw;
      b.qx   = {a.qx[QW-2:0], 1'b1};
    end else begin
      b.remx = rsx;
      b.qx   = {a.qx[QW-2:0], 1'b0};
    end
    if (rsy >= rw) begin
      b.remy = rsy - rw;
      b.qy   = {a.qy[QW-2:0], 1'b1};
    end else begin
      b.remy = rsy;
      b.qy   = {a.qy[QW-2:0], 1'b0};
    end
    b.tx = a.tx << 1;
    b.ty = a.ty << 1;
    return b;
  endfunction

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES:0]   rdy;
  dv_t                   st  [DIV_STAGES];
  dv_t                   nxt [DIV_STAGES];

  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  // quotient never exceeds one, so the dividend starts at mx/2 below r
  always_comb begin
    dv_t cur;
    cur.remx = (ROOTW+1)'(in_mx >> 1);
    cur.remy = (ROOTW+1)'(in_my >> 1);
    cur.qx   = '0;
    cur.qy   = '0;
    cur.tx   = {in_mx[0], {FRAC{1'b0}}};
    cur.ty   = {in_my[0], {FRAC{1'b0}}};
    cur.r    = in_root;
    cur.item = in_item;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k > 0) begin
        cur = st[k-1];
      end
      for (int j = 0; j < 2; j++) begin
        if (2 * k + j < QW) begin
          cur = dv_step(cur);
        end
      end
      nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_item  = st[DIV_STAGES-1].item;
  assign out_root  = st[DIV_STAGES-1].r;
  assign out_qx    = st[DIV_STAGES-1].qx;
  assign out_qy    = st[DIV_STAGES-1].qy;

endmodule

// ===== design/obcq_back.sv =====
// ----------------------------------------------------------------------------
// obcq_back
// Corner result merge, rotation back to world frame, clamp, output register.
// ----------------------------------------------------------------------------
module obcq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  obcq_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  obcq_pkg::item_t               in_item,
  input  logic [obcq_pkg::ROOTW-1:0]    in_root,
  input  logic [obcq_pkg::QW-1:0]       in_qx,
  input  logic [obcq_pkg::QW-1:0]       in_qy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [obcq_pkg::CW-1:0] distance,
  output logic signed [obcq_pkg::NW-1:0] normal_x,
  output logic signed [obcq_pkg::NW-1:0] normal_y,
  output logic [1:0]                    region
);
  import obcq_pkg::*;

  localparam int CDW = ROOTW + (1 << SW) - 1;
  localparam int XPW = NW + AW;
  localparam int WXW = XPW + 1 - FRAC;

  logic [BACK_STAGES-1:0] v;
  logic [BACK_STAGES:0]   rdy;

  logic signed [CW-1:0]  dist1, dist2;
  logic signed [NW-1:0]  nx1, ny1;
  region_t               reg1, reg2;
  logic signed [XPW-1:0] pxx, pyy, pyx, pxy;

  logic [CDW-1:0]        cw;
  logic signed [CW-1:0]  dist_c;
  logic signed [NW-1:0]  nx_c, ny_c;
  logic [XPW:0]          sx, sy;
  logic signed [WXW-1:0] wx, wy;
  logic signed [NW-1:0]  wx_c, wy_c;

  always_comb begin
    rdy[BACK_STAGES] = out_ready;
    for (int k = BACK_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_comb begin
    cw     = CDW'(in_root) << in_item.sh;
    dist_c = in_item.sdist;
    nx_c   = in_item.nx;
    ny_c   = in_item.ny;
    if (in_item.corner) begin
      dist_c = (cw > CDW'(DIST_MAX)) ? DIST_MAX : $signed(cw[CW-1:0]);
      if (in_root == '0) begin
        nx_c = '0;
        ny_c = '0;
      end else begin
        nx_c = in_item.neg_x ? -$signed(NW'(in_qx)) : $signed(NW'(in_qx));
        ny_c = in_item.neg_y ? -$signed(NW'(in_qy)) : $signed(NW'(in_qy));
      end
    end
  end

  always_comb begin
    sx = {pxx[XPW-1], pxx} - {pyy[XPW-1], pyy};
    sy = {pyx[XPW-1], pyx} + {pxy[XPW-1], pxy};
    wx = $signed(sx[XPW:FRAC]);
    wy = $signed(sy[XPW:FRAC]);
    if (wx > N_POS) begin
      wx_c = N_POS;
    end else if (wx < N_NEG) begin
      wx_c = N_NEG;
    end else begin
      wx_c = wx[NW-1:0];
    end
    if (wy > N_POS) begin
      wy_c = N_POS;
    end else if (wy < N_NEG) begin
      wy_c = N_NEG;
    end else begin
      wy_c = wy[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < BACK_STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dist1 <= dist_c;
      nx1   <= nx_c;
      ny1   <= ny_c;
      reg1  <= in_item.region;
    end
    if (rdy[1]) begin
      dist2 <= dist1;
      reg2  <= reg1;
      pxx   <= nx1 * $signed(cfg.axis_x);
      pyy   <= ny1 * $signed(cfg.axis_y);
      pyx   <= ny1 * $signed(cfg.axis_x);
      pxy   <= nx1 * $signed(cfg.axis_y);
    end
    if (rdy[2]) begin
      distance <= dist2;
      normal_x <= wx_c;
      normal_y <= wy_c;
      region   <= reg2;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[BACK_STAGES-1];

endmodule

// ===== design/obcq_checker.sv =====
// ----------------------------------------------------------------------------
// obcq_checker
// Port-level checks on occupancy, stall behaviour and reset.
// ----------------------------------------------------------------------------
module obcq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [obcq_pkg::CW-1:0] distance,
  input logic signed [obcq_pkg::NW-1:0] normal_x,
  input logic signed [obcq_pkg::NW-1:0] normal_y,
  input logic [1:0]                    region
);
  import obcq_pkg::*;

  localparam int CNTW = $clog2(PIPE_DEPTH + 2);

  logic [CNTW-1:0] cnt;
  logic            in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CNTW'(in_beat) - CNTW'(out_beat);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(normal_x)
      && $stable(normal_y) && $stable(region))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != '0)
    else $error("result beat without an outstanding item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(PIPE_DEPTH))
    else $error("more items in flight than stages");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

endmodule

bind oriented_box_collision_query obcq_checker u_chk (.*);

// ===== test/oriented_box_collision_query_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oriented_box_collision_query_tb
// Streams query points through the block under several box settings and
// compares every result beat with a fixed-point prediction of the distance,
// world normal and region, with random idling on both sides.
// ----------------------------------------------------------------------------
module oriented_box_collision_query_tb;
  import obcq_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam int SETTLE = PIPE_DEPTH + 8;

  typedef struct {
    logic signed [CW-1:0] sdist;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    region_t              zone;
  } box_hit_t;

  class box_scoreboard;
    longint cx, cy, w, h, ax, ay, m;
    box_hit_t pending_hits[$];

    function new();
      cx = 0; cy = 0; w = 65536; h = 65536; ax = 65536; ay = 0; m = 1311;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_CENTER_X:    cx = longint'($signed(v));
        CFG_CENTER_Y:    cy = longint'($signed(v));
        CFG_HALF_WIDTH:  w  = longint'(v[30:0]);
        CFG_HALF_HEIGHT: h  = longint'(v[30:0]);
        CFG_AXIS_X:      ax = longint'($signed(v[17:0]));
        CFG_AXIS_Y:      ay = longint'($signed(v[17:0]));
        CFG_MARGIN:      m  = longint'(v[16:0]);
        default: ;
      endcase
    endfunction

    function longint absl(longint v);
      return v < 0 ? -v : v;
    endfunction

    function int nearest_face(longint c0, longint c1, longint c2, longint c3);
      longint c[4];
      int best;
      c[0] = c0; c[1] = c1; c[2] = c2; c[3] = c3;
      best = 0;
      for (int k = 1; k < 4; k++)
        if (absl(c[k]) < absl(c[best])) best = k;
      return best;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_query(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy);
      longint dx, dy, lx, ly, e, d, nx, ny, ex, ey, wx, wy;
      bit [63:0] mx, my, r;
      bit xl, xh, yl, yh;
      int s, k;
      box_hit_t hit;
      dx = longint'(qx) - cx;
      dy = longint'(qy) - cy;
      lx = (dx * ax + dy * ay) >>> FRAC;
      ly = (dy * ax - dx * ay) >>> FRAC;
      e = m >> 1;
      nx = 0; ny = 0;
      if (lx < -w - e || ly < -h - e || lx > w + e || ly > h + e) begin
        xl = lx < -w - m; xh = lx > w + m;
        yl = ly < -h - m; yh = ly > h + m;
        if ((xl || xh) && (yl || yh)) begin
          ex = lx - (xl ? (-w - m) : (w + m));
          ey = ly - (yl ? (-h - m) : (h + m));
          mx = absl(ex); my = absl(ey);
          s = 0;
          while ((mx >> s) >= (64'd1 << 31) || (my >> s) >= (64'd1 << 31)) s++;
          mx = mx >> s; my = my >> s;
          r = int_sqrt(mx * mx + my * my);
          d = ((r << s) > 64'h7FFFFFFF) ? 64'h7FFFFFFF : longint'(r << s);
          if (r != 0) begin
            nx = longint'((mx << FRAC) / r);
            ny = longint'((my << FRAC) / r);
            if (ex < 0) nx = -nx;
            if (ey < 0) ny = -ny;
          end
          hit.zone = REG_CORNER;
        end else begin
          hit.zone = REG_SIDE;
          if (xl) begin
            d = -w - m - lx; nx = -ONE;
          end else if (xh) begin
            d = lx - w - m; nx = ONE;
          end else if (yl) begin
            d = -h - m - ly; ny = -ONE;
          end else if (yh) begin
            d = ly - h - m; ny = ONE;
          end else begin
            k = nearest_face(lx + w + m, w + m - lx, ly + h + m, h + m - ly);
            case (k)
              0: begin d = -(lx + w + m); nx = -ONE; end
              1: begin d = -(w + m - lx); nx = ONE; end
              2: begin d = -(ly + h + m); ny = -ONE; end
              default: begin d = -(h + m - ly); ny = ONE; end
            endcase
            hit.zone = REG_SHELL;
          end
        end
      end else begin
        k = nearest_face(lx + w, w - lx, ly + h, h - ly);
        case (k)
          0: begin d = lx + w; nx = ONE; end
          1: begin d = w - lx; nx = -ONE; end
          2: begin d = ly + h; ny = ONE; end
          default: begin d = h - ly; ny = -ONE; end
        endcase
        hit.zone = REG_INSIDE;
      end
      wx = clampl((nx * ax - ny * ay) >>> FRAC, -ONE, ONE);
      wy = clampl((ny * ax + nx * ay) >>> FRAC, -ONE, ONE);
      hit.sdist = CW'(clampl(d, -64'sd2147483648, 64'sd2147483647));
      hit.nx = NW'(wx);
      hit.ny = NW'(wy);
      pending_hits.push_back(hit);
    endfunction

    function string check(logic signed [CW-1:0] got_dist, logic signed [NW-1:0] nx,
                          logic signed [NW-1:0] ny, logic [1:0] zone);
      box_hit_t x;
      string msg;
      if (pending_hits.size() == 0) return "result beat with nothing expected";
      x = pending_hits.pop_front();
      msg = "";
      if (got_dist !== x.sdist)
        msg = {msg, $sformatf(" distance %0d/%0d", got_dist, x.sdist)};
      if (nx !== x.nx) msg = {msg, $sformatf(" normal_x %0d/%0d", nx, x.nx)};
      if (ny !== x.ny) msg = {msg, $sformatf(" normal_y %0d/%0d", ny, x.ny)};
      if (zone !== x.zone) msg = {msg, $sformatf(" region %0d/%0d", zone, x.zone)};
      return msg;
    endfunction

    function int outstanding();
      return pending_hits.size();
    endfunction
  endclass

  logic                 clk, rst;
  logic                 cfg_write;
  logic [2:0]           cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid, in_stall;
  logic signed [CW-1:0] query_x, query_y;
  logic                 out_valid, out_stall;
  logic signed [CW-1:0] distance;
  logic signed [NW-1:0] normal_x, normal_y;
  logic [1:0]           region;

  box_scoreboard sb = new();
  int errors = 0;
  int tx_max = 4, rx_max = 4;
  int gap_left = 0, hold_left = 0;

  oriented_box_collision_query i_dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic report(string s);
    errors++;
    $display("mismatch at %0t:%s", $realtime, s);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1; hold_left--;
    end else if (gap_left > 0) begin
      out_stall <= 1'b1; gap_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      msg = sb.check(distance, normal_x, normal_y, region);
      if (msg != "") report(msg);
      gap_left = $urandom_range(0, rx_max);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_query(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy);
    int n;
    n = $urandom_range(0, tx_max);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1; query_x <= qx; query_y <= qy;
    do @(posedge clk); while (in_stall);
    sb.note_query(qx, qy);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_box(longint cx, longint cy, longint w, longint h,
                          logic [31:0] ax, logic [31:0] ay, logic [31:0] m);
    write_reg(CFG_CENTER_X, 32'(cx));
    write_reg(CFG_CENTER_Y, 32'(cy));
    write_reg(CFG_HALF_WIDTH, 32'(w));
    write_reg(CFG_HALF_HEIGHT, 32'(h));
    write_reg(CFG_AXIS_X, ax);
    write_reg(CFG_AXIS_Y, ay);
    write_reg(CFG_MARGIN, m);
    write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic random_query();
    longint lim, ox, oy;
    if ($urandom_range(0, 3) == 0) begin
      send_query($urandom, $urandom);
    end else begin
      lim = sb.w + sb.h + 2 * sb.m + 1024;
      if ($urandom_range(0, 2) == 0) lim = 2 * sb.m + 64;
      if (lim > 64'h7FFFFFFF) lim = 64'h7FFFFFFF;
      ox = longint'($signed($urandom)) % (lim + 1);
      oy = longint'($signed($urandom)) % (lim + 1);
      if (lim == 2 * sb.m + 64) begin
        ox = ox + (($urandom_range(0, 1) != 0) ? sb.w : -sb.w);
        if ($urandom_range(0, 1) != 0) oy = oy + sb.h;
      end
      send_query(CW'(sb.cx + ox), CW'(sb.cy + oy));
    end
  endtask

  initial begin
    int sel;
    logic [31:0] ax, ay;
    rst = 1'b1; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; query_x = '0; query_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_box(0, 0, 65536, 65536, 65536, 0, 1311);
    send_query(0, 0);
    send_query(32768, 0);
    send_query(65536 + 300, 0);
    send_query(65536 + 1000, 0);
    send_query(-65536 - 1000, 0);
    send_query(0, 65536 + 1000);
    send_query(0, -70000);
    send_query(200000, 0);
    send_query(-200000, 0);
    send_query(0, 200000);
    send_query(0, -200000);
    send_query(200000, 200000);
    send_query(-200000, -200000);
    send_query(200000, -200000);
    send_query(-200000, 200000);
    send_query(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_query(32'sh80000000, 32'sh80000000);
    send_query(32'sh7FFFFFFF, 32'sh80000000);
    send_query(32'sh80000000, 0);
    send_query(0, 32'sh7FFFFFFF);
    drain();

    load_box(-64'sd2147483648, 64'sd2147483647, 0, 0, 0, 65536, 0);
    send_query(32'sh7FFFFFFF, 32'sh80000000);
    send_query(32'sh80000000, 32'sh7FFFFFFF);
    send_query(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    for (int i = 0; i < 100; i++) random_query();
    drain();

    for (int p = 0; p < 7; p++) begin
      sel = $urandom_range(0, 3);
      ax = (sel == 0) ? 32'd46341 : (sel == 1) ? -32'sd46341 :
           (sel == 2) ? 32'd65536 : 32'd0;
      ay = (sel == 0) ? -32'sd46341 : (sel == 1) ? 32'd46341 :
           (sel == 2) ? 32'd0 : -32'sd65536;
      case (p)
        0: load_box($urandom_range(0, 1 << 20), 0, 64'h7FFFFFFF, 64'h7FFFFFFF,
                    -32'sd65536, 0, 65536);
        1: load_box(longint'($signed($urandom)) >>> 4, longint'($signed($urandom)) >>> 4,
                    $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                    32'd46341, -32'sd46341, $urandom_range(0, 65536));
        2: load_box(longint'($signed($urandom)), longint'($signed($urandom)),
                    $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                    $urandom, $urandom, $urandom);
        default: load_box(longint'($signed($urandom)) >>> 2,
                          longint'($signed($urandom)) >>> 2,
                          (p == 5) ? longint'($urandom) : $urandom_range(0, 1 << 22),
                          (p == 5) ? longint'($urandom) : $urandom_range(0, 1 << 22),
                          ax, ay, $urandom_range(0, 65536));
      endcase
      tx_max = (p == 4) ? 0 : 4;
      rx_max = (p == 4) ? 0 : 4;
      for (int i = 0; i < 120; i++) begin
        if (p == 1 && i == 10) begin
          hold_left = 150;
        end
        if (p == 2 && i == 60) drain();
        random_query();
      end
      drain();
    end

    if (errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
